/* rtl/core/ihfl_pkg.sv */
// Package for the Intel HEX flash loader: result kinds, record types, states and queue entries.
// No dependencies.
package ihfl_pkg;

   typedef enum logic [1:0] {
      KIND_FILL   = 2'd0,
      KIND_COMMIT = 2'd1,
      KIND_ACK    = 2'd2,
      KIND_FINAL  = 2'd3
   } kind_type;

   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF  = 8'h01;
   localparam logic [7:0] REC_SEG  = 8'h02;
   localparam logic [7:0] REC_SSA  = 8'h03;
   localparam logic [7:0] REC_LIN  = 8'h04;
   localparam logic [7:0] REC_SLA  = 8'h05;
   localparam logic [7:0] MIN_LINE = 8'd11;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [31:0] LIMIT_RESET = 32'd16384;

   localparam logic [0:0] CSR_FLASH_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DATA,
      BK_EOF_FINAL
   } back_state_type;

   // one finished line handed from front to back
   typedef struct packed {
      logic        invalid;
      logic        sum_bad;
      logic [7:0]  rec_len;
      logic [15:0] rec_off;
      logic [7:0]  rec_type;
   } line_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
      return v;
   endfunction

endpackage

/* rtl/core/ihfl_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface ihfl_if #(parameter int W = 8) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/ihfl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ihfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

/* rtl/core/ihfl_front.sv */
// Front end: decodes characters of one line, writes data bytes to the data RAM,
// and pushes a line summary on end of line. Depends on ihfl_pkg.
module ihfl_front import ihfl_pkg::*; #(
   parameter int MAX_DATA_BYTES = 64,
   parameter int AW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic          in_op,
   input  logic [7:0]    in_ch,
   output logic          in_ready,
   input  logic          q_full,
   output logic          push,
   output line_type      push_line,
   output logic          ram_we,
   output logic [AW-1:0] ram_waddr,
   output logic [7:0]    ram_wdata
);
   localparam logic [8:0] MAXB = 9'(MAX_DATA_BYTES);

   logic [7:0]  cnt_ff, cnt_in;
   logic [3:0]  nib_ff, nib_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] off_ff, off_in;
   logic [7:0]  typ_ff, typ_in;
   logic [7:0]  sum_ff, sum_in;
   logic        bad_ff, bad_in;

   logic [7:0] byte_v;
   logic [6:0] b;
   logic [8:0] dix;
   logic [9:0] need;

   // the data RAM is shared, so no character of the next line enters while the back end runs
   assign in_ready = !q_full;
   assign byte_v   = {nib_ff, hex_value(in_ch)};
   assign b        = 7'(cnt_ff[7:1] - 7'd1);
   assign dix      = 9'(b) - 9'd4;
   assign need     = 10'(MIN_LINE) + {1'b0, len_ff, 1'b0};

   always_comb begin
      cnt_in = cnt_ff; nib_in = nib_ff; len_in = len_ff; off_in = off_ff;
      typ_in = typ_ff; sum_in = sum_ff; bad_in = bad_ff;
      ram_we = 1'b0; ram_waddr = dix[AW-1:0]; ram_wdata = byte_v;
      push = 1'b0;
      push_line.invalid = bad_ff || cnt_ff < MIN_LINE || 10'(cnt_ff) < need ||
                          9'(len_ff) > MAXB;
      push_line.sum_bad = sum_ff != 8'd0;
      push_line.rec_len = len_ff;
      push_line.rec_off = off_ff;
      push_line.rec_type = typ_ff;
      if (in_valid && in_ready) begin
         if (in_op) begin
            push = 1'b1;
            cnt_in = '0; nib_in = '0; len_in = '0; off_in = '0;
            typ_in = '0; sum_in = '0; bad_in = 1'b0;
         end else if (cnt_ff != 8'd255) begin
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'd0) begin
               if (in_ch != CH_COLON) bad_in = 1'b1;
            end else if (cnt_ff[0]) begin
               nib_in = hex_value(in_ch);
            end else if (9'(b) <= 9'd4 + 9'(len_ff)) begin
               sum_in = sum_ff + byte_v;
               case (b)
                  7'd0: begin
                     len_in = byte_v;
                     if (9'(byte_v) > MAXB) bad_in = 1'b1;
                  end
                  7'd1: off_in = {byte_v, off_ff[7:0]};
                  7'd2: off_in = {off_ff[15:8], byte_v};
                  7'd3: typ_in = byte_v;
                  default: begin
                     if (9'(b) < 9'd4 + 9'(len_ff) && dix < MAXB) ram_we = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; nib_ff <= '0; len_ff <= '0; off_ff <= '0;
         typ_ff <= '0; sum_ff <= '0; bad_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; nib_ff <= nib_in; len_ff <= len_in; off_ff <= off_in;
         typ_ff <= typ_in; sum_ff <= sum_in; bad_ff <= bad_in;
      end
   end
endmodule

/* rtl/core/ihfl_back.sv */
// Back end: runs one queued record, reads data bytes from RAM, emits results.
// Depends on ihfl_pkg.
module ihfl_back import ihfl_pkg::*; #(
   parameter int MAX_DATA_BYTES = 64,
   parameter int PAGE_BYTES = 128,
   parameter int AW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [31:0]   limit,
   input  logic          q_valid,
   input  line_type      q_line,
   output logic          pop,
   output logic [AW-1:0] ram_raddr,
   input  logic [7:0]    ram_rdata,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [1:0]    out_kind,
   output logic [31:0]   out_address,
   output logic [15:0]   out_word,
   output logic          out_ok,
   output logic          out_last
);
   localparam logic [31:0] PMASK = 32'(PAGE_BYTES - 1);

   back_state_type st_ff, st_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] page_ff, page_in;
   logic        err_ff, err_in;
   line_type    ln_ff, ln_in;
   logic [7:0]  dp_ff, dp_in;      // byte pointer in data record
   logic [1:0]  ph_ff, ph_in;      // 0 read low, 1 read high, 2 emit fill or address ack, 3 emit commit or ack
   logic [7:0]  lo_ff, lo_in;
   logic [31:0] addr_ff, addr_in;

   logic        ov_ff, ov_in;
   logic [1:0]  ok_kind_ff, ok_kind_in;
   logic [31:0] oa_ff, oa_in;
   logic [15:0] ow_ff, ow_in;
   logic        oo_ff, oo_in, ol_ff, ol_in;

   logic        slot;
   logic [32:0] endsum;
   logic [31:0] start_a;
   logic [8:0]  rd_ix;

   assign slot    = !ov_ff || out_ready;
   assign start_a = base_ff + 32'(q_line.rec_off);
   assign endsum  = 33'(base_ff) + 33'(q_line.rec_off) + 33'(q_line.rec_len);
   assign rd_ix   = (ph_ff == 2'd0) ? 9'(dp_ff) : 9'(dp_ff) + 9'd1;
   assign ram_raddr = rd_ix[AW-1:0];

   always_comb begin
      logic [7:0] rd;
      logic [7:0] hi;
      logic       inr;
      rd = 8'd0;
      hi = 8'd0;
      st_in = st_ff; base_in = base_ff; page_in = page_ff; err_in = err_ff;
      ln_in = ln_ff; dp_in = dp_ff; ph_in = ph_ff; lo_in = lo_ff;
      addr_in = addr_ff;
      ov_in = ov_ff && !out_ready;
      ok_kind_in = ok_kind_ff; oa_in = oa_ff; ow_in = ow_ff; oo_in = oo_ff; ol_in = ol_ff;
      pop = 1'b0;
      inr = 1'b0;
      case (st_ff)
         BK_IDLE: begin
            if (q_valid && slot) begin
               pop = 1'b1;
               ln_in = q_line;
               ov_in = 1'b1; ok_kind_in = KIND_ACK; oa_in = '0; ow_in = '0; ol_in = 1'b1;
               if (q_line.invalid) begin
                  err_in = 1'b1; oo_in = 1'b0;
               end else begin
                  if (q_line.sum_bad) err_in = 1'b1;
                  case (q_line.rec_type)
                     REC_DATA: begin
                        if (endsum > 33'(limit)) err_in = 1'b1;
                        if (q_line.rec_len != 8'd0) begin
                           ov_in = 1'b0;
                           st_in = BK_DATA; dp_in = '0; ph_in = 2'd0; addr_in = start_a;
                        end
                     end
                     REC_SEG, REC_LIN: begin
                        ov_in = 1'b0;
                        st_in = BK_DATA; dp_in = '0; ph_in = 2'd0;
                     end
                     REC_SSA, REC_SLA: ;
                     REC_EOF: begin
                        ok_kind_in = KIND_COMMIT; oa_in = page_ff + 32'(PAGE_BYTES);
                        ol_in = 1'b0; st_in = BK_EOF_FINAL;
                     end
                     default: err_in = 1'b1;
                  endcase
                  oo_in = !err_in;
                  if (q_line.rec_type == REC_EOF) oo_in = 1'b0;
               end
            end
         end
         BK_EOF_FINAL: begin
            if (slot) begin
               ov_in = 1'b1; ok_kind_in = KIND_FINAL; oa_in = '0; ow_in = '0;
               oo_in = !err_ff; ol_in = 1'b1; st_in = BK_IDLE;
            end
         end
         BK_DATA: begin
            // ram data of the previous phase
            case (ph_ff)
               2'd0: ph_in = 2'd1;
               2'd1: begin
                  inr = 9'(dp_ff) < 9'(ln_ff.rec_len) && 9'(dp_ff) < 9'(MAX_DATA_BYTES);
                  lo_in = inr ? ram_rdata : 8'd0;
                  ph_in = 2'd2;
               end
               2'd2: begin
                  if (slot) begin
                     rd = ram_rdata;
                     inr = 9'(dp_ff) + 9'd1 < 9'(ln_ff.rec_len) &&
                           9'(dp_ff) + 9'd1 < 9'(MAX_DATA_BYTES);
                     hi = inr ? rd : 8'd0;
                     if (ln_ff.rec_type == REC_DATA) begin
                        ov_in = 1'b1; ok_kind_in = KIND_FILL; oa_in = addr_ff & PMASK;
                        ow_in = {hi, lo_ff}; oo_in = 1'b0; ol_in = 1'b0;
                        if ((addr_ff & PMASK) == 32'(PAGE_BYTES - 2)) begin
                           ph_in = 2'd3;
                        end else if (9'(dp_ff) + 9'd2 >= 9'(ln_ff.rec_len)) begin
                           ph_in = 2'd3;
                        end else begin
                           ph_in = 2'd0; dp_in = dp_ff + 8'd2; addr_in = addr_ff + 32'd2;
                        end
                     end else begin
                        if (ln_ff.rec_type == REC_SEG)
                           base_in = 32'({lo_ff, hi}) << 4;
                        else
                           base_in = 32'({lo_ff, hi}) << 16;
                        ov_in = 1'b1; ok_kind_in = KIND_ACK; oa_in = '0; ow_in = '0;
                        oo_in = !err_ff; ol_in = 1'b1; st_in = BK_IDLE;
                     end
                  end
               end
               default: begin
                  if (slot) begin
                     ov_in = 1'b1; ow_in = '0; oo_in = 1'b0; ol_in = 1'b0;
                     if ((addr_ff & PMASK) == 32'(PAGE_BYTES - 2) && ok_kind_ff == KIND_FILL) begin
                        page_in = addr_ff & ~PMASK;
                        ok_kind_in = KIND_COMMIT; oa_in = addr_ff & ~PMASK;
                        if (9'(dp_ff) + 9'd2 < 9'(ln_ff.rec_len)) begin
                           ph_in = 2'd0; dp_in = dp_ff + 8'd2; addr_in = addr_ff + 32'd2;
                        end else begin
                           ok_kind_in = KIND_COMMIT;
                           ph_in = 2'd3; dp_in = 8'hFF;
                        end
                     end else begin
                        ok_kind_in = KIND_ACK; oa_in = '0; oo_in = !err_ff; ol_in = 1'b1;
                        st_in = BK_IDLE;
                     end
                  end else begin
                     ov_in = ov_ff && !out_ready;
                  end
               end
            endcase
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE; base_ff <= '0; page_ff <= '0; err_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; base_ff <= base_in; page_ff <= page_in; err_ff <= err_in;
         ov_ff <= ov_in;
      end
      ln_ff <= ln_in; dp_ff <= dp_in; ph_ff <= ph_in; lo_ff <= lo_in;
      addr_ff <= addr_in; ok_kind_ff <= ok_kind_in; oa_ff <= oa_in; ow_ff <= ow_in;
      oo_ff <= oo_in; ol_ff <= ol_in;
   end

   assign out_valid   = ov_ff;
   assign out_kind    = ok_kind_ff;
   assign out_address = oa_ff;
   assign out_word    = ow_ff;
   assign out_ok      = oo_ff;
   assign out_last    = ol_ff;

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> ov_ff && $stable(oa_ff)) else $error("result dropped");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> st_ff == BK_IDLE) else $error("pop while busy");
   a_final: assert property (@(posedge clock) disable iff (reset)
      st_ff == BK_EOF_FINAL |-> ok_kind_ff == KIND_COMMIT) else $error("final order");
`endif
endmodule

/* rtl/core/intel_hex_flash_loader_top.sv */
// Top level of the Intel HEX flash loader: CSR port, front, line queue, data RAM, back.
// Depends on ihfl_pkg, ihfl_if, ihfl_ram, ihfl_front, ihfl_back.
//  channel  dir  payload
//  req      in   op, ch
//  rsp      out  kind, address, word, ok, last
//  csr      in   APB, flash_limit_bytes at 0
// After an end of line, req.ready stays low until the back end has emitted the last
// result of that line (one-entry queue, data RAM shared). For each word a data record
// reads the low byte, reads the high byte and emits a fill; it adds a commit per page
// end and an ack, bounded by the single RAM read port. Synchronous active-high reset;
// no clearing pass. rsp stalls hold the back end and, through the queue, the req channel.
module intel_hex_flash_loader_top import ihfl_pkg::*; #(
   parameter int MAX_DATA_BYTES = 64,
   parameter int PAGE_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   ihfl_if.sink        req,
   ihfl_if.source      rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(MAX_DATA_BYTES);

   logic [31:0] limit_ff;
   logic        q_valid_ff;
   line_type    q_line_ff;
   logic        push, pop, we;
   line_type    push_line;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]  wdata, rdata;
   logic [1:0]  kind;
   logic [31:0] addr;
   logic [15:0] word;
   logic        ok, last;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1] == CSR_FLASH_LIMIT) ? limit_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= LIMIT_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1] == CSR_FLASH_LIMIT)
         limit_ff <= csr_pwdata;
   end

   // queue busy until back end finishes the line (RAM shared)
   logic busy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0; busy_ff <= 1'b0;
      end else begin
         if (push) begin
            q_valid_ff <= 1'b1; busy_ff <= 1'b1;
         end else if (pop) q_valid_ff <= 1'b0;
         if (rsp.valid && rsp.ready && last && !push) busy_ff <= 1'b0;
      end
      if (push) q_line_ff <= push_line;
   end

   ihfl_front #(.MAX_DATA_BYTES(MAX_DATA_BYTES), .AW(AW)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_op(req.payload[8]), .in_ch(req.payload[7:0]),
      .in_ready(req.ready), .q_full(busy_ff),
      .push, .push_line, .ram_we(we), .ram_waddr(waddr), .ram_wdata(wdata)
   );

   ihfl_ram #(.WIDTH(8), .DEPTH(MAX_DATA_BYTES)) u_ram (
      .clock, .we, .waddr, .wdata, .raddr, .rdata
   );

   ihfl_back #(.MAX_DATA_BYTES(MAX_DATA_BYTES), .PAGE_BYTES(PAGE_BYTES), .AW(AW)) u_back (
      .clock, .reset, .limit(limit_ff),
      .q_valid(q_valid_ff), .q_line(q_line_ff), .pop,
      .ram_raddr(raddr), .ram_rdata(rdata),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_kind(kind), .out_address(addr), .out_word(word), .out_ok(ok), .out_last(last)
   );

   assign rsp.payload = {kind, addr, word, ok, last};
endmodule

/* verif/tb_intel_hex_flash_loader_top.sv */
// Testbench for the Intel HEX flash loader: streams HEX lines, predicts fills, commits and acks.
// Depends on ihfl_pkg, ihfl_if and intel_hex_flash_loader_top.
`timescale 1ns / 100ps

module tb_intel_hex_flash_loader_top;
   import ihfl_pkg::*;

   localparam int MAX_BYTES = 64;
   localparam int PAGE = 128;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      kind_type    kind;
      logic [31:0] address;
      logic [15:0] word;
      logic        ok;
      logic        last;
   } loader_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = 2'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ihfl_if #(9)  req_if (clock);
   ihfl_if #(52) rsp_if (clock);

   intel_hex_flash_loader_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   // loader image kept by the testbench
   int unsigned  p_count;
   logic [3:0]   p_nibble;
   logic [7:0]   p_len;
   logic [15:0]  p_off;
   logic [7:0]   p_type;
   logic [7:0]   p_sum;
   logic         p_hbad;
   logic [7:0]   p_data [MAX_BYTES];
   logic [31:0]  p_base;
   logic [31:0]  p_page;
   logic         p_sticky;
   logic [31:0]  p_limit;

   loader_result_type loader_results_q[$];
   loader_result_type line_out_q[$];
   logic [7:0]        line_bytes[$];
   logic [7:0]        line_chars[$];
   int  errors = 0;
   int  cycles = 0;
   bit  idle_on = 1'b1;
   int  stall_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // sample at the falling edge, ahead of the accepting rising edge
   always @(negedge clock) begin
      loader_result_type e;
      logic [51:0] p;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         p = rsp_if.payload;
         if (loader_results_q.size() == 0) begin
            $display("%0t unexpected transaction: actual %h", $realtime, p);
            errors++;
         end else begin
            e = loader_results_q.pop_front();
            if (p[51:50] != e.kind || p[49:18] != e.address || p[17:2] != e.word ||
                p[1] != e.ok || p[0] != e.last) begin
               $display("%0t mismatch: expected kind %0d addr %h word %h ok %b last %b",
                        $realtime, e.kind, e.address, e.word, e.ok, e.last);
               $display("%0t          actual   kind %0d addr %h word %h ok %b last %b",
                        $realtime, p[51:50], p[49:18], p[17:2], p[1], p[0]);
               errors++;
            end
         end
      end
   end

   function automatic logic [3:0] digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      return 4'd0;
   endfunction

   function automatic logic [7:0] byte_at(int unsigned i);
      if (i < p_len && i < MAX_BYTES) return p_data[i];
      return 8'd0;
   endfunction

   function automatic void clear_line_state();
      p_count = 0; p_nibble = 0; p_len = 0; p_off = 0; p_type = 0; p_sum = 0; p_hbad = 0;
   endfunction

   function automatic void add_result(kind_type k, logic [31:0] a, logic [15:0] w, logic ok);
      loader_result_type r;
      r.kind = k; r.address = a; r.word = w; r.ok = ok; r.last = 1'b0;
      line_out_q.push_back(r);
   endfunction

   function automatic void predict_char(logic [7:0] c);
      int unsigned pos;
      int unsigned b;
      logic [7:0]  v;
      pos = p_count;
      if (pos >= 255) return;
      p_count = pos + 1;
      if (pos == 0) begin
         if (c != CH_COLON) p_hbad = 1'b1;
         return;
      end
      if (pos & 1) begin
         p_nibble = digit_of(c);
         return;
      end
      v = {p_nibble, digit_of(c)};
      b = pos / 2 - 1;
      if (b > 4 + p_len) return;
      p_sum = p_sum + v;
      if (b == 0) begin
         p_len = v;
         if (v > MAX_BYTES) p_hbad = 1'b1;
      end else if (b == 1) p_off[15:8] = v;
      else if (b == 2) p_off[7:0] = v;
      else if (b == 3) p_type = v;
      else if (b < 4 + p_len && b - 4 < MAX_BYTES) p_data[b - 4] = v;
   endfunction

   function automatic void predict_line_end();
      bit          invalid;
      bit          eof;
      logic [31:0] start;
      logic [31:0] addr;
      logic [31:0] inpage;
      logic [32:0] top;
      line_out_q.delete();
      eof = 1'b0;
      invalid = p_hbad || p_count < MIN_LINE || p_count < MIN_LINE + 2 * p_len ||
                p_len > MAX_BYTES;
      if (invalid) begin
         p_sticky = 1'b1;
         add_result(KIND_ACK, 0, 0, 1'b0);
      end else begin
         if (p_sum != 0) p_sticky = 1'b1;
         case (p_type)
            REC_DATA: begin
               start = p_base + p_off;
               top = {1'b0, p_base} + p_off + p_len;
               if (top > {1'b0, p_limit}) p_sticky = 1'b1;
               for (int dp = 0; dp < p_len; dp += 2) begin
                  addr = start + dp;
                  inpage = addr & (PAGE - 1);
                  add_result(KIND_FILL, inpage, {byte_at(dp + 1), byte_at(dp)}, 1'b0);
                  if (inpage == PAGE - 2) begin
                     p_page = addr & ~32'(PAGE - 1);
                     add_result(KIND_COMMIT, p_page, 0, 1'b0);
                  end
               end
            end
            REC_SEG: p_base = {12'd0, byte_at(0), byte_at(1), 4'd0};
            REC_LIN: p_base = {byte_at(0), byte_at(1), 16'd0};
            REC_SSA, REC_SLA: ;
            REC_EOF: begin
               add_result(KIND_COMMIT, p_page + PAGE, 0, 1'b0);
               add_result(KIND_FINAL, 0, 0, ~p_sticky);
               eof = 1'b1;
            end
            default: p_sticky = 1'b1;
         endcase
         if (!eof) add_result(KIND_ACK, 0, 0, ~p_sticky);
      end
      clear_line_state();
      line_out_q[line_out_q.size() - 1].last = 1'b1;
      foreach (line_out_q[i]) loader_results_q.push_back(line_out_q[i]);
   endfunction

   task automatic send_item(logic op, logic [7:0] c);
      bit taken;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= {op, c};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_if.ready;
         if (taken) begin
            if (op) predict_line_end();
            else predict_char(c);
         end
         @(posedge clock);
      end
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n);
      return (n < 10) ? 8'("0" + n) : 8'("A" + n - 10);
   endfunction

   // fills line_bytes with length, offset, type and random data
   task automatic build_record(int len, logic [15:0] off, logic [7:0] typ);
      line_bytes.delete();
      line_bytes.push_back(8'(len));
      line_bytes.push_back(off[15:8]);
      line_bytes.push_back(off[7:0]);
      line_bytes.push_back(typ);
      for (int i = 0; i < len; i++) line_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // fault: 0 clean, 1 bad checksum, 2 no colon, 3 truncated, 4 noise char, 5 trailing junk,
   // 6 trailing junk past the saturated character count
   task automatic send_line(int fault);
      logic [7:0] s;
      int cut;
      s = 0;
      foreach (line_bytes[i]) s = s + line_bytes[i];
      s = -s;
      if (fault == 1) s = s ^ 8'(1 << $urandom_range(0, 7));
      line_chars.delete();
      line_chars.push_back((fault == 2) ? 8'($urandom_range(0, 255)) : CH_COLON);
      foreach (line_bytes[i]) begin
         line_chars.push_back(hex_char(line_bytes[i][7:4]));
         line_chars.push_back(hex_char(line_bytes[i][3:0]));
      end
      line_chars.push_back(hex_char(s[7:4]));
      line_chars.push_back(hex_char(s[3:0]));
      if (fault == 3) begin
         cut = $urandom_range(1, line_chars.size() - 1);
         while (line_chars.size() > cut) void'(line_chars.pop_back());
      end
      if (fault == 4)
         line_chars[$urandom_range(1, line_chars.size() - 1)] = 8'($urandom_range(0, 255));
      if (fault == 5)
         repeat ($urandom_range(1, 6)) line_chars.push_back(8'($urandom_range(0, 255)));
      if (fault == 6)
         while (line_chars.size() < 257) line_chars.push_back(8'($urandom_range(0, 255)));
      foreach (line_chars[i]) send_item(1'b0, line_chars[i]);
      send_item(1'b1, 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (loader_results_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] v);
      wait_idle();
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= 2'd0; csr_pwdata <= v;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      p_limit = v;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_records();
      build_record(5, 16'h007A, REC_DATA); send_line(0);
      build_record(2, 16'h0000, REC_SEG);
      line_bytes[4] = 8'h01; line_bytes[5] = 8'h00; send_line(0);
      build_record(2, 16'h0010, REC_DATA); send_line(0);
      build_record(1, 16'h0000, REC_SEG); send_line(0);
      build_record(0, 16'h0000, REC_SSA); send_line(0);
      build_record(2, 16'h0000, REC_LIN);
      line_bytes[4] = 8'h00; line_bytes[5] = 8'h00; send_line(0);
   endtask

   task automatic test_limits();
      write_limit(32'd130);
      build_record(4, 16'h007E, REC_DATA); send_line(0);
      build_record(4, 16'h0080, REC_DATA); send_line(0);
      write_limit(LIMIT_RESET);
   endtask

   task automatic test_errors();
      string txt;
      build_record(0, 16'h0000, REC_DATA); send_line(1);
      send_line(2);
      send_line(3);
      build_record(0, 16'h0000, 8'h07); send_line(0);
      build_record(0, 16'h0000, REC_DATA); line_bytes[0] = 8'h41; send_line(0);
      // non-hex digits decode as zero
      txt = ":0G00XX0ab";
      for (int i = 0; i < txt.len(); i++) send_item(1'b0, txt[i]);
      send_item(1'b1, 8'h00);
      send_item(1'b1, 8'hFF);
   endtask

   task automatic test_final();
      // longest record, then enough junk to saturate the line counter
      build_record(MAX_BYTES, 16'hFFC0, REC_DATA); send_line(6);
      build_record(0, 16'h0000, REC_EOF); send_line(0);
   endtask

   initial begin
      for (int i = 0; i < MAX_BYTES; i++) p_data[i] = 8'd0;
      clear_line_state();
      p_base = 0; p_page = 0; p_sticky = 0; p_limit = LIMIT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_records();
      test_limits();
      test_errors();
      idle_on = 1'b0;
      test_final();
      req_if.valid <= 1'b0;
      while (loader_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
